@@ src/kme_pkg.sv @@
// ----------------------------------------------------------------------------
// kme_pkg
// Shared word types and status codes of the Kruskal maze edge merger.
// ----------------------------------------------------------------------------
package kme_pkg;

    typedef struct packed {
        logic       action;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic       direction;
    } t_kme_in;

    typedef struct packed {
        logic [2:0] status;
        logic       maze_done;
        logic [8:0] sets_remaining;
    } t_kme_out;

    localparam logic [2:0] ST_OPENED   = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_SAME     = 3'd2;
    localparam logic [2:0] ST_COMPLETE = 3'd3;
    localparam logic [2:0] ST_RESTART  = 3'd4;

endpackage

@@ src/kme_ram.sv @@
// ----------------------------------------------------------------------------
// kme_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kme_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 11,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/kme_ctrl.sv @@
// ----------------------------------------------------------------------------
// kme_ctrl
// Sequencer of the maze merger: wall checks, label compare, relabel scan and
// clearing pass over the cell memory, plus the remaining-set count.
// ----------------------------------------------------------------------------
module kme_ctrl #(
    parameter int GRID_SIDE = 16,
    parameter int CELLS     = 256,
    parameter int AW        = 8,
    parameter int LW        = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  kme_pkg::t_kme_in      i_data,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output kme_pkg::t_kme_out     o_res,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [LW+1:0]         o_wdata,
    output logic [AW-1:0]         o_raddr,
    input  logic [LW+1:0]         i_rdata
);

    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CHK    = 7'b0000100,
        S_CMP    = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_RESULT = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_issue, n_issue;
    logic          r_rd_vld, n_rd_vld;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_here, n_here;
    logic          r_dir, n_dir;
    logic [LW-1:0] r_a, n_a;
    logic [LW-1:0] r_b, n_b;
    logic [LW-1:0] r_sets, n_sets;
    logic [2:0]    r_status, n_status;
    logic          r_clr_res, n_clr_res;

    logic [AW-1:0] w_here;
    logic [AW-1:0] w_there;
    logic          w_outside;
    logic          w_border;
    logic [LW-1:0] w_lbl;
    logic          w_accept;

    assign w_here  = AW'(32'(i_data.cell_y) * GRID_SIDE + 32'(i_data.cell_x));
    assign w_there = r_here + (r_dir ? AW'(GRID_SIDE) : AW'(1));
    assign w_outside = (32'(i_data.cell_x) >= GRID_SIDE) || (32'(i_data.cell_y) >= GRID_SIDE);
    assign w_border  = i_data.direction ? (32'(i_data.cell_y) == GRID_SIDE - 1)
                                        : (32'(i_data.cell_x) == GRID_SIDE - 1);
    assign w_lbl    = i_rdata[LW-1:0];
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_issue   = r_issue;
        n_rd_vld  = 1'b0;
        n_rd_addr = r_cnt;
        n_here    = r_here;
        n_dir     = r_dir;
        n_a       = r_a;
        n_b       = r_b;
        n_sets    = r_sets;
        n_status  = r_status;
        n_clr_res = r_clr_res;
        o_we      = 1'b0;
        o_waddr   = r_cnt;
        o_wdata   = {2'b00, LW'(r_cnt) + LW'(1)};
        o_raddr   = r_cnt;

        unique case (r_state)
            S_CLEAR: begin
                o_we = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_cnt    = '0;
                    n_sets   = LW'(CELLS);
                    n_status = kme_pkg::ST_RESTART;
                    n_state  = r_clr_res ? S_RESULT : S_IDLE;
                end
            end
            S_IDLE: begin
                o_raddr = w_here;
                if (w_accept) begin
                    n_here = w_here;
                    n_dir  = i_data.direction;
                    if (i_data.action) begin
                        n_cnt     = '0;
                        n_clr_res = 1'b1;
                        n_state   = S_CLEAR;
                    end else if (r_sets == LW'(1)) begin
                        n_status = kme_pkg::ST_COMPLETE;
                        n_state  = S_RESULT;
                    end else if (w_outside || w_border) begin
                        n_status = kme_pkg::ST_BLOCKED;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                // Word of the proposing cell is on the read port now.
                o_raddr = w_there;
                n_a     = w_lbl;
                if (r_dir ? i_rdata[LW+1] : i_rdata[LW]) begin
                    n_status = kme_pkg::ST_BLOCKED;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_b = w_lbl;
                if (w_lbl == r_a) begin
                    n_status = kme_pkg::ST_SAME;
                    n_state  = S_RESULT;
                end else begin
                    n_cnt   = '0;
                    n_issue = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read one cell a cycle; the write-back of a cell comes in the cycle after its
                // read, so while reads are issued the two never address the same entry.
                o_raddr   = r_cnt;
                n_rd_vld  = r_issue;
                n_rd_addr = r_cnt;
                if (r_issue) begin
                    if (r_cnt == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                    end
                end
                o_we    = r_rd_vld;
                o_waddr = r_rd_addr;
                o_wdata = i_rdata;
                if (w_lbl == r_b) begin
                    o_wdata[LW-1:0] = r_a;
                end
                if (r_rd_addr == r_here) begin
                    if (r_dir) begin
                        o_wdata[LW+1] = 1'b1;
                    end else begin
                        o_wdata[LW] = 1'b1;
                    end
                end
                if (r_rd_vld && (r_rd_addr == LAST)) begin
                    n_sets   = r_sets - LW'(1);
                    n_status = kme_pkg::ST_OPENED;
                    n_state  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_clr_res = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_sets    <= LW'(CELLS);
            r_clr_res <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_issue   <= n_issue;
            r_rd_vld  <= n_rd_vld;
            r_sets    <= n_sets;
            r_clr_res <= n_clr_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_here    <= n_here;
        r_dir     <= n_dir;
        r_a       <= n_a;
        r_b       <= n_b;
        r_status  <= n_status;
    end

    assign o_res_valid          = (r_state == S_RESULT);
    assign o_res.status         = r_status;
    assign o_res.maze_done      = (r_sets == LW'(1));
    assign o_res.sets_remaining = 9'(r_sets);

    a_sets_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sets != '0)
        else $error("set count reached zero");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == S_CLEAR || r_state == S_SCAN))
        else $error("memory write outside clear or scan");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_we && r_issue) |-> (o_waddr != o_raddr))
        else $error("scan read and write hit the same cell");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.action) |=> (r_state == S_CLEAR && r_cnt == '0))
        else $error("restart did not start the clearing pass");

endmodule

@@ src/kruskal_maze_edge_merger_top.sv @@
// ----------------------------------------------------------------------------
// kruskal_maze_edge_merger_top
// Processing: a restart runs a clearing pass and an accepted merge a relabel
// scan, each over all CELLS cells (CELLS = GRID_SIDE squared).
// Throughput: one word at a time; the merge rate is set by the relabel scan,
// one cell memory read-modify-write per cycle.
// Reset: synchronous; afterwards a clearing pass over all cells initializes
// the cell memory, and no input word is accepted until it ends.
// ----------------------------------------------------------------------------
module kruskal_maze_edge_merger_top #(
    parameter int GRID_SIDE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kme_pkg::t_kme_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output kme_pkg::t_kme_out o_data
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);

    logic              w_res_valid;
    logic              w_res_ready;
    kme_pkg::t_kme_out w_res;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [LW+1:0]     w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [LW+1:0]     w_rdata;

    logic              r_out_vld;
    kme_pkg::t_kme_out r_out;

    kme_ctrl #(
        .GRID_SIDE (GRID_SIDE),
        .CELLS     (CELLS),
        .AW        (AW),
        .LW        (LW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // Cell word: down wall, right wall, set label.
    kme_ram #(
        .DEPTH (CELLS),
        .WIDTH (LW + 2),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_res_ready = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
